// File: hw/rtl/reed_beacon_scheduler_core_assert.svh
// assertion macros used by the scheduler checker
`ifndef REED_BEACON_SCHEDULER_CORE_ASSERT_SVH
`define REED_BEACON_SCHEDULER_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define RBS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scheduler assertion failed");

// next-cycle implication, disabled while reset is low
`define RBS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scheduler assertion failed");

`endif

// File: hw/rtl/rbs_pkg.sv
// shared types and constants of the reed beacon scheduler
package rbs_pkg;

    // packet kinds
    typedef enum logic [1:0] {
        KIND_HEARTBEAT = 2'd0,
        KIND_CHANGE    = 2'd1,
        KIND_SELFTEST  = 2'd2
    } t_kind;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_IDENT            = 3'd0,
        REG_CLOSED_LEVEL     = 3'd1,
        REG_HEARTBEAT_PERIOD = 3'd2,
        REG_SELFTEST_PERIOD  = 3'd3,
        REG_BURST_GAP        = 3'd4,
        REG_FAULT_DAYS       = 3'd5,
        REG_BOOT_BAG         = 3'd6,
        REG_SAVED_DAYS       = 3'd7
    } t_reg_idx;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [1:0] POWER_GOOD = 2'd3;

    // health bit positions
    localparam int unsigned HEALTH_REED_FAULT  = 0;
    localparam int unsigned HEALTH_BOOT_CONTRA = 1;

    // register reset values
    localparam logic [31:0] RST_IDENT            = 32'h0000_AB01;
    localparam logic        RST_CLOSED_LEVEL     = 1'b0;
    localparam logic [15:0] RST_HEARTBEAT_PERIOD = 16'd60;
    localparam logic [19:0] RST_SELFTEST_PERIOD  = 20'd864000;
    localparam logic [7:0]  RST_BURST_GAP        = 8'd20;
    localparam logic [7:0]  RST_FAULT_DAYS       = 8'd30;
    localparam logic        RST_BOOT_BAG         = 1'b0;
    localparam logic [7:0]  RST_SAVED_DAYS       = 8'd0;

    // counter saturation limits
    localparam logic [15:0] HB_MAX  = 16'hFFFF;
    localparam logic [19:0] ST_MAX  = 20'hF_FFFF;
    localparam logic [7:0]  DAY_MAX = 8'hFF;

    // configuration register file contents
    typedef struct packed {
        logic [31:0] ident;
        logic        closed_level;
        logic [15:0] heartbeat_period;
        logic [19:0] selftest_period;
        logic [7:0]  burst_gap;
        logic [7:0]  fault_days;
        logic        boot_bag;
        logic [7:0]  saved_days;
    } t_cfg;

    // input stage to scheduler
    typedef struct packed {
        logic valid;
        logic level;
    } t_stage;

    // scheduler back to input stage
    typedef struct packed {
        logic take;
    } t_stage_ack;

endpackage

// File: hw/rtl/reed_beacon_scheduler_core.sv
// Reed beacon scheduler: one input word is one poll tick carrying the raw reed level.
// Each tick yields zero or one packet word (heartbeat, state-change burst packet or
// self-test burst packet). A new tick word is taken every cycle unless the output stalls.
// A tick passes the input register, then the decision logic into the result register, on
// its way to the output. Throughput is one tick per cycle, limited only by the output side:
// a held result stalls the decision stage until taken.
// Configuration writes are taken every cycle and should only be issued while idle.
module reed_beacon_scheduler_core #(
    parameter int unsigned BURST_LENGTH = 5
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // tick words
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_reed_level,
    // packet words
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [31:0]                    o_packet_id,
    output logic                           o_bag_open,
    output logic [1:0]                     o_power_level,
    output logic [7:0]                     o_sequence_res,
    output logic [1:0]                     o_kind,
    output logic [1:0]                     o_health_bits,
    output logic [7:0]                     o_days_unchanged,
    // configuration writes
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [rbs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rbs_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    rbs_pkg::t_cfg       cfg;
    rbs_pkg::t_stage     stage;
    rbs_pkg::t_stage_ack ack;

    // configuration registers
    rbs_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // input register
    rbs_in_stage u_in (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_reed_level (i_reed_level),
        .o_stage      (stage),
        .i_ack        (ack)
    );

    // decision logic and result register
    rbs_sched #(
        .BURST_LENGTH (BURST_LENGTH)
    ) u_sched (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (cfg),
        .i_stage          (stage),
        .o_ack            (ack),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_packet_id      (o_packet_id),
        .o_bag_open       (o_bag_open),
        .o_power_level    (o_power_level),
        .o_sequence_res   (o_sequence_res),
        .o_kind           (o_kind),
        .o_health_bits    (o_health_bits),
        .o_days_unchanged (o_days_unchanged)
    );

endmodule

// File: hw/rtl/rbs_cfg_regs.sv
// configuration register file of the reed beacon scheduler
module rbs_cfg_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [rbs_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [rbs_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output rbs_pkg::t_cfg                      o_cfg
);

    rbs_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // register writes, masked to each register's width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ident            <= rbs_pkg::RST_IDENT;
            r_cfg.closed_level     <= rbs_pkg::RST_CLOSED_LEVEL;
            r_cfg.heartbeat_period <= rbs_pkg::RST_HEARTBEAT_PERIOD;
            r_cfg.selftest_period  <= rbs_pkg::RST_SELFTEST_PERIOD;
            r_cfg.burst_gap        <= rbs_pkg::RST_BURST_GAP;
            r_cfg.fault_days       <= rbs_pkg::RST_FAULT_DAYS;
            r_cfg.boot_bag         <= rbs_pkg::RST_BOOT_BAG;
            r_cfg.saved_days       <= rbs_pkg::RST_SAVED_DAYS;
        end else if (i_cfg_valid) begin
            case (rbs_pkg::t_reg_idx'(i_cfg_index))
                rbs_pkg::REG_IDENT: begin
                    r_cfg.ident <= i_cfg_data[31:0];
                end
                rbs_pkg::REG_CLOSED_LEVEL: begin
                    r_cfg.closed_level <= i_cfg_data[0];
                end
                rbs_pkg::REG_HEARTBEAT_PERIOD: begin
                    r_cfg.heartbeat_period <= i_cfg_data[15:0];
                end
                rbs_pkg::REG_SELFTEST_PERIOD: begin
                    r_cfg.selftest_period <= i_cfg_data[19:0];
                end
                rbs_pkg::REG_BURST_GAP: begin
                    r_cfg.burst_gap <= i_cfg_data[7:0];
                end
                rbs_pkg::REG_FAULT_DAYS: begin
                    r_cfg.fault_days <= i_cfg_data[7:0];
                end
                rbs_pkg::REG_BOOT_BAG: begin
                    r_cfg.boot_bag <= i_cfg_data[0];
                end
                rbs_pkg::REG_SAVED_DAYS: begin
                    r_cfg.saved_days <= i_cfg_data[7:0];
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// File: hw/rtl/rbs_in_stage.sv
// input register stage holding one sampled tick word
module rbs_in_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_reed_level,
    output rbs_pkg::t_stage     o_stage,
    input  rbs_pkg::t_stage_ack i_ack
);

    logic r_valid;
    logic r_level;

    // room when empty or when the held word moves on this cycle
    assign o_ready       = !r_valid || i_ack.take;
    assign o_stage.valid = r_valid;
    assign o_stage.level = r_level;

    // occupancy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_level <= i_reed_level;
        end
    end

endmodule

// File: hw/rtl/rbs_sched.sv
// scheduler state, per-tick decision logic and result register
module rbs_sched #(
    parameter int unsigned BURST_LENGTH = 5
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rbs_pkg::t_cfg       i_cfg,
    input  rbs_pkg::t_stage     i_stage,
    output rbs_pkg::t_stage_ack o_ack,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [31:0]         o_packet_id,
    output logic                o_bag_open,
    output logic [1:0]          o_power_level,
    output logic [7:0]          o_sequence_res,
    output logic [1:0]          o_kind,
    output logic [1:0]          o_health_bits,
    output logic [7:0]          o_days_unchanged
);

    localparam int unsigned BLW = $clog2(BURST_LENGTH + 1);
    localparam logic [BLW-1:0] BURST_RELOAD = BLW'(BURST_LENGTH - 1);

    // scheduler state
    logic           r_started,  n_started;
    logic           r_stable,   n_stable;
    logic           r_pending,  n_pending;
    logic [15:0]    r_hb,       n_hb;
    logic [19:0]    r_st,       n_st;
    logic [BLW-1:0] r_left,     n_left;
    logic [1:0]     r_bkind,    n_bkind;
    logic [7:0]     r_gap,      n_gap;
    logic [7:0]     r_seq,      n_seq;
    logic [1:0]     r_health,   n_health;
    logic [7:0]     r_day,      n_day;

    // result register
    logic           r_out_valid;
    logic [31:0]    r_out_id;
    logic           r_out_bag;
    logic [7:0]     r_out_seq;
    logic [1:0]     r_out_kind;
    logic [1:0]     r_out_health;
    logic [7:0]     r_out_days;

    logic           take;
    logic           bag;
    logic           emit;
    logic [1:0]     e_kind;
    logic [19:0]    st_inc;
    logic [15:0]    hb_inc;
    logic [7:0]     gap_dec;
    logic [7:0]     gap_load;
    logic [7:0]     day_inc;

    // a tick is processed when the result register can take its word
    assign take       = i_stage.valid && (!r_out_valid || i_ready);
    assign o_ack.take = take;

    assign bag      = (i_stage.level == i_cfg.closed_level) ? 1'b0 : 1'b1;
    assign st_inc   = (r_st < rbs_pkg::ST_MAX) ? r_st + 20'd1 : r_st;
    assign hb_inc   = (r_hb < rbs_pkg::HB_MAX) ? r_hb + 16'd1 : r_hb;
    assign gap_dec  = r_gap - 8'd1;
    assign gap_load = (i_cfg.burst_gap == 8'd0) ? 8'd1 : i_cfg.burst_gap;
    assign day_inc  = (r_day < rbs_pkg::DAY_MAX) ? r_day + 8'd1 : r_day;

    // per-tick decision
    always_comb begin
        n_started = r_started;
        n_stable  = r_stable;
        n_pending = r_pending;
        n_hb      = r_hb;
        n_st      = r_st;
        n_left    = r_left;
        n_bkind   = r_bkind;
        n_gap     = r_gap;
        n_health  = r_health;
        n_day     = r_day;
        emit      = 1'b0;
        e_kind    = rbs_pkg::KIND_HEARTBEAT;

        if (!r_started) begin
            // first tick: load persisted values and check the boot state
            n_started = 1'b1;
            n_day     = i_cfg.saved_days;
            n_health[rbs_pkg::HEALTH_BOOT_CONTRA] = (i_cfg.boot_bag != bag);
            n_health[rbs_pkg::HEALTH_REED_FAULT]  = (i_cfg.saved_days >= i_cfg.fault_days);
            n_stable  = bag;
            n_pending = 1'b0;
            n_hb      = 16'd0;
            n_st      = 20'd0;
            emit      = 1'b1;
            e_kind    = rbs_pkg::KIND_HEARTBEAT;
        end else begin
            n_st = st_inc;
            if (r_gap != 8'd0) begin
                // burst running: count the gap down
                n_gap = gap_dec;
                if (gap_dec == 8'd0) begin
                    if (r_left != '0) begin
                        emit   = 1'b1;
                        e_kind = r_bkind;
                        n_left = r_left - BLW'(1);
                        n_gap  = gap_load;
                    end else begin
                        n_hb    = 16'd0;
                        n_bkind = rbs_pkg::KIND_HEARTBEAT;
                    end
                end
            end else begin
                n_hb = hb_inc;
                if ((bag != r_stable) && r_pending) begin
                    // confirmed change starts a change burst
                    n_stable  = bag;
                    n_day     = 8'd0;
                    n_health[rbs_pkg::HEALTH_REED_FAULT] = 1'b0;
                    emit      = 1'b1;
                    e_kind    = rbs_pkg::KIND_CHANGE;
                end else begin
                    n_pending = (bag != r_stable);
                    if (st_inc >= i_cfg.selftest_period) begin
                        // daily self test
                        n_day = day_inc;
                        if (day_inc >= i_cfg.fault_days) begin
                            n_health[rbs_pkg::HEALTH_REED_FAULT] = 1'b1;
                        end
                        n_st   = 20'd0;
                        emit   = 1'b1;
                        e_kind = rbs_pkg::KIND_SELFTEST;
                    end else if (hb_inc >= i_cfg.heartbeat_period) begin
                        n_hb   = 16'd0;
                        emit   = 1'b1;
                        e_kind = rbs_pkg::KIND_HEARTBEAT;
                    end
                end
                // burst start
                if (emit && (e_kind != rbs_pkg::KIND_HEARTBEAT)) begin
                    n_bkind   = e_kind;
                    n_left    = BURST_RELOAD;
                    n_gap     = gap_load;
                    n_pending = 1'b0;
                end
            end
        end
    end

    assign n_seq = emit ? r_seq + 8'd1 : r_seq;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
            r_stable  <= 1'b0;
            r_pending <= 1'b0;
            r_hb      <= '0;
            r_st      <= '0;
            r_left    <= '0;
            r_bkind   <= '0;
            r_gap     <= '0;
            r_seq     <= '0;
            r_health  <= '0;
            r_day     <= '0;
        end else if (take) begin
            r_started <= n_started;
            r_stable  <= n_stable;
            r_pending <= n_pending;
            r_hb      <= n_hb;
            r_st      <= n_st;
            r_left    <= n_left;
            r_bkind   <= n_bkind;
            r_gap     <= n_gap;
            r_seq     <= n_seq;
            r_health  <= n_health;
            r_day     <= n_day;
        end
    end

    // result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= emit;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload; health and days only travel with a self test
    always_ff @(posedge i_clk) begin
        if (take && emit) begin
            r_out_id   <= i_cfg.ident;
            r_out_bag  <= bag;
            r_out_seq  <= r_seq;
            r_out_kind <= e_kind;
            if (e_kind == rbs_pkg::KIND_SELFTEST) begin
                r_out_health <= n_health;
                r_out_days   <= n_day;
            end else begin
                r_out_health <= 2'd0;
                r_out_days   <= 8'd0;
            end
        end
    end

    assign o_valid          = r_out_valid;
    assign o_packet_id      = r_out_id;
    assign o_bag_open       = r_out_bag;
    assign o_power_level    = rbs_pkg::POWER_GOOD;
    assign o_sequence_res   = r_out_seq;
    assign o_kind           = r_out_kind;
    assign o_health_bits    = r_out_health;
    assign o_days_unchanged = r_out_days;

endmodule

// File: hw/rtl/rbs_checker.sv
// port-level checker for the reed beacon scheduler, bound to the top level
`include "reed_beacon_scheduler_core_assert.svh"

module rbs_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_seq,
    input logic [1:0] i_kind,
    input logic [1:0] i_power,
    input logic [1:0] i_health,
    input logic [7:0] i_days
);

    logic       r_have;
    logic [7:0] r_last_seq;

    // remember the sequence number of the last delivered word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have     <= 1'b0;
            r_last_seq <= '0;
        end else if (i_out_valid && i_out_ready) begin
            r_have     <= 1'b1;
            r_last_seq <= i_seq;
        end
    end

    // a stalled word holds
    `RBS_ASSERT_NXT(a_stall_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_seq) && $stable(i_kind))

    // sequence numbers start at zero and step by one per delivered word
    `RBS_ASSERT_IMP(a_seq_first, i_clk, i_rst_n, i_out_valid && !r_have, i_seq == 8'd0)
    `RBS_ASSERT_IMP(a_seq_step, i_clk, i_rst_n, i_out_valid && r_have, i_seq == r_last_seq + 8'd1)

    // health and day count only ride on self-test packets, power always good
    `RBS_ASSERT_IMP(a_selftest_only, i_clk, i_rst_n, i_out_valid && (i_kind != rbs_pkg::KIND_SELFTEST), (i_health == 2'd0) && (i_days == 8'd0) && (i_power == rbs_pkg::POWER_GOOD))

endmodule

bind reed_beacon_scheduler_core rbs_checker u_rbs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_valid),
    .i_out_ready (i_ready),
    .i_seq       (o_sequence_res),
    .i_kind      (o_kind),
    .i_power     (o_power_level),
    .i_health    (o_health_bits),
    .i_days      (o_days_unchanged)
);
